// ----- src/nan_skipping_region_mean_and_runs_assert.svh -----
// assertion macros used by the checker file
`ifndef NAN_SKIPPING_REGION_MEAN_AND_RUNS_ASSERT_SVH
`define NAN_SKIPPING_REGION_MEAN_AND_RUNS_ASSERT_SVH

// same-cycle implication, reset masks the check
`define NSRM_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("nsrm assertion failed");

// next-cycle implication, reset masks the check
`define NSRM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("nsrm assertion failed");

`endif

// ----- src/nsrm_pkg.sv -----
package nsrm_pkg;

	// count saturation limit
	localparam int unsigned MAX_SPAN = 65536;

	localparam int POS_W = 32;
	localparam int VAL_W = 32;
	localparam int SUM_W = 48;
	localparam int CNT_W = $clog2(MAX_SPAN + 1);
	localparam int STEP_W = $clog2(SUM_W);

	typedef logic [POS_W-1:0] pos_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [1:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_LIMIT_ON = 2'd0;
	localparam cfg_idx_t REG_START    = 2'd1;
	localparam cfg_idx_t REG_END      = 2'd2;
	localparam cfg_idx_t REG_MODE     = 2'd3;

	// result kinds and modes
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_MEAN   = 1'b1;
	localparam logic MODE_AVG    = 1'b0;
	localparam logic MODE_RUNS   = 1'b1;

endpackage

// ----- src/nan_skipping_region_mean_and_runs.sv -----
// channel | direction | handshake            | word
// in      | input     | in_valid / in_stall  | item_start, item_end, position, sample_value,
//         |           |                      | missing, item_last
// out     | output    | out_valid / out_stall| result_kind, span_start, span_end,
//         |           |                      | result_value, new_run
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// words are captured, then evaluated; in runs mode a kept one waits while the output is held
// the last word of an item in average mode with kept samples then runs prep, divide and finish:
// the mean goes through one shared 18-bit compare/subtract unit, one quotient bit per cycle
// in_stall is high from the capture until the word is fully handled
// the output register holds a result under out_stall while new words are captured
// arst_n clears control state and the accumulators; config registers take their defaults
module nan_skipping_region_mean_and_runs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  nsrm_pkg::pos_t   item_start,
	input  nsrm_pkg::pos_t   item_end,
	input  nsrm_pkg::pos_t   position,
	input  nsrm_pkg::value_t sample_value,
	input  logic             missing,
	input  logic             item_last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             result_kind,
	output nsrm_pkg::pos_t   span_start,
	output nsrm_pkg::pos_t   span_end,
	output nsrm_pkg::value_t result_value,
	output logic             new_run,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  nsrm_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]      cfg_data
);
	import nsrm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SPAN);
	localparam logic [SUM_W-1:0] POS_LIM = SUM_W'(64'h7FFF_FFFF);
	localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(64'h8000_0000);

	logic [2:0] state_q;

	// configuration
	logic limit_on_q;
	pos_t reg_start_q;
	pos_t reg_end_q;
	logic mode_q;

	// captured input word
	pos_t   istart_q;
	pos_t   iend_q;
	pos_t   pos_q;
	value_t val_q;
	logic   miss_q;
	logic   last_q;

	// accumulator and run state
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	pos_t             first_q;
	pos_t             lastpos_q;
	logic             run_q;

	// divider
	logic [SUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	pos_t              dstart_q;
	pos_t              dend_q;

	// output register
	logic   ovalid_q;
	logic   okind_q;
	pos_t   ostart_q;
	pos_t   oend_q;
	value_t oval_q;
	logic   orun_q;

	logic             out_free;
	logic             out_set;
	pos_t             lo;
	pos_t             hi;
	logic             kept;
	logic             emit_pb;
	logic             eval_go;
	logic             fresh;
	logic [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0] cnt_n;
	pos_t             first_n;
	pos_t             lastpos_n;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             qbit;
	value_t           mean_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !ovalid_q || !out_stall;

	// clipped range and keep test
	always_comb begin
		lo = istart_q;
		hi = iend_q;
		if (limit_on_q) begin
			if (reg_start_q > istart_q) lo = reg_start_q;
			if (reg_end_q < iend_q) hi = reg_end_q;
		end
		kept = !miss_q && (pos_q >= lo) && (pos_q < hi);
	end

	assign emit_pb = (mode_q == MODE_RUNS) && kept;
	assign eval_go = !emit_pb || out_free;
	assign fresh   = !run_q || (pos_q != lastpos_q + 32'd1);
	assign out_set = ((state_q == ST_EVAL) && emit_pb && out_free)
		|| ((state_q == ST_FIN) && out_free);

	// next accumulator values in average mode
	always_comb begin
		sum_n     = sum_q;
		cnt_n     = cnt_q;
		first_n   = first_q;
		lastpos_n = lastpos_q;
		if (kept) begin
			if (cnt_q == '0) first_n = pos_q;
			lastpos_n = pos_q;
			if (cnt_q < CNT_MAX) begin
				sum_n = sum_q + {{(SUM_W-VAL_W){val_q[VAL_W-1]}}, val_q};
				cnt_n = cnt_q + 1'b1;
			end
		end
	end

	// shared compare/subtract step of the divider
	assign trial = {rem_q, num_q[SUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	// rounded mean, saturated to 32 bits
	always_comb begin
		if (neg_q) begin
			mean_sat = (num_q > NEG_LIM) ? value_t'(NEG_LIM[VAL_W-1:0])
				: value_t'(-num_q[VAL_W-1:0]);
		end else begin
			mean_sat = (num_q > POS_LIM) ? value_t'(POS_LIM[VAL_W-1:0])
				: value_t'(num_q[VAL_W-1:0]);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_on_q  <= 1'b0;
			reg_start_q <= '0;
			reg_end_q   <= '1;
			mode_q      <= MODE_AVG;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMIT_ON: limit_on_q  <= cfg_data[0];
				REG_START:    reg_start_q <= cfg_data;
				REG_END:      reg_end_q   <= cfg_data;
				REG_MODE:     mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			istart_q <= item_start;
			iend_q   <= item_end;
			pos_q    <= position;
			val_q    <= sample_value;
			miss_q   <= missing;
			last_q   <= item_last;
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			cnt_q     <= '0;
			first_q   <= '0;
			lastpos_q <= '0;
			run_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (eval_go) begin
						if (mode_q == MODE_RUNS) begin
							state_q <= ST_IDLE;
							if (kept) lastpos_q <= pos_q;
							run_q <= kept && !last_q;
							if (last_q) begin
								sum_q <= '0;
								cnt_q <= '0;
							end
						end else begin
							sum_q     <= last_q ? '0 : sum_n;
							cnt_q     <= last_q ? '0 : cnt_n;
							first_q   <= first_n;
							lastpos_q <= lastpos_n;
							state_q   <= (last_q && cnt_n != '0) ? ST_PREP : ST_IDLE;
							if (last_q) run_q <= 1'b0;
						end
					end
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == '0) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_set) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && emit_pb && out_free) begin
			okind_q  <= KIND_SAMPLE;
			ostart_q <= pos_q;
			oend_q   <= pos_q + 32'd1;
			oval_q   <= val_q;
			orun_q   <= fresh;
		end else if (state_q == ST_FIN && out_free) begin
			okind_q  <= KIND_MEAN;
			ostart_q <= dstart_q;
			oend_q   <= dend_q;
			oval_q   <= mean_sat;
			orun_q   <= 1'b0;
		end
	end

	// divider datapath: load, magnitude plus half count, then one bit a cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_EVAL: begin
				num_q    <= sum_n;
				den_q    <= cnt_n;
				dstart_q <= first_n;
				dend_q   <= lastpos_n + 32'd1;
			end
			ST_PREP: begin
				neg_q  <= num_q[SUM_W-1];
				num_q  <= (num_q[SUM_W-1] ? -num_q : num_q)
					+ {{(SUM_W-CNT_W+1){1'b0}}, den_q[CNT_W-1:1]};
				rem_q  <= '0;
				step_q <= STEP_W'(SUM_W - 1);
			end
			ST_DIV: begin
				num_q  <= {num_q[SUM_W-2:0], qbit};
				rem_q  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
				step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid    = ovalid_q;
	assign result_kind  = okind_q;
	assign span_start   = ostart_q;
	assign span_end     = oend_q;
	assign result_value = oval_q;
	assign new_run      = orun_q;

endmodule

// ----- src/nsrm_checker.sv -----
module nsrm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             result_kind,
	input nsrm_pkg::pos_t   span_start,
	input nsrm_pkg::pos_t   span_end,
	input logic             new_run
);
	import nsrm_pkg::*;
	`include "nan_skipping_region_mean_and_runs_assert.svh"

	// a held result stays offered
	`NSRM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// an accepted word always raises in_stall
	`NSRM_ASSERT_NEXT(a_in_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// a mean never opens a run
	`NSRM_ASSERT_NOW(a_mean_norun, clk, arst_n, out_valid && result_kind == KIND_MEAN, !new_run)
	// a per-base word covers exactly one position
	`NSRM_ASSERT_NOW(a_sample_span, clk, arst_n, out_valid && result_kind == KIND_SAMPLE,
		span_end == span_start + 32'd1)

endmodule

bind nan_skipping_region_mean_and_runs nsrm_checker u_nsrm_checker (.*);

// ----- bench/nan_skipping_region_mean_and_runs_tb.sv -----
module nan_skipping_region_mean_and_runs_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nsrm_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 70;
	localparam int PHASES = 10;

	typedef struct packed {
		logic   kind;
		pos_t   first;
		pos_t   stop;
		value_t val;
		logic   fresh;
	} span_word_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	pos_t     item_start = '0;
	pos_t     item_end = '0;
	pos_t     position = '0;
	value_t   sample_value = '0;
	logic     missing = 1'b0;
	logic     item_last = 1'b0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	logic     result_kind;
	pos_t     span_start;
	pos_t     span_end;
	value_t   result_value;
	logic     new_run;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index = REG_LIMIT_ON;
	logic [31:0] cfg_data = '0;

	// mirror of the block's settings and accumulators
	logic             clip_on = 1'b0;
	pos_t             clip_lo = '0;
	pos_t             clip_hi = '1;
	logic             run_mode = MODE_AVG;
	logic [SUM_W-1:0] sum_acc = '0;
	logic [CNT_W-1:0] count_acc = '0;
	pos_t             first_pos = '0;
	pos_t             last_pos = '0;
	logic             run_live = 1'b0;

	span_word_t pending_spans[$];
	int mismatch_count = 0;
	int words_sent = 0;
	int quiet_cycles = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	nan_skipping_region_mean_and_runs uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.item_start(item_start),
		.item_end(item_end),
		.position(position),
		.sample_value(sample_value),
		.missing(missing),
		.item_last(item_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.span_start(span_start),
		.span_end(span_end),
		.result_value(result_value),
		.new_run(new_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// keep test, run tracking and item mean for one accepted word
	function automatic bit track_sample(input pos_t istart, iend, pos, input value_t val,
		input logic miss, last, output span_word_t res);
		pos_t lo, hi;
		bit kept, made;
		longint signed total;
		longint unsigned mag, quo;
		lo = istart;
		hi = iend;
		made = 1'b0;
		res = '0;
		if (clip_on) begin
			if (clip_lo > lo) lo = clip_lo;
			if (clip_hi < hi) hi = clip_hi;
		end
		kept = !miss && pos >= lo && pos < hi;
		if (run_mode == MODE_RUNS) begin
			if (kept) begin
				res.kind = KIND_SAMPLE;
				res.first = pos;
				res.stop = pos + 32'd1;
				res.val = val;
				res.fresh = !run_live || pos != last_pos + 32'd1;
				made = 1'b1;
				last_pos = pos;
				run_live = 1'b1;
			end else begin
				run_live = 1'b0;
			end
		end else begin
			if (kept) begin
				if (count_acc == 0) first_pos = pos;
				last_pos = pos;
				if (count_acc < MAX_SPAN) begin
					sum_acc = sum_acc + {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
					count_acc = count_acc + 1'b1;
				end
			end
			if (last && count_acc != 0) begin
				// rounded to nearest, ties away from zero, clamped to 32 bits
				total = {{(64-SUM_W){sum_acc[SUM_W-1]}}, sum_acc};
				mag = (total < 0) ? -total : total;
				quo = (mag + count_acc / 2) / count_acc;
				if (total < 0) begin
					if (quo > 64'h8000_0000) quo = 64'h8000_0000;
					quo = 64'd0 - quo;
				end else if (quo > 64'h7FFF_FFFF) begin
					quo = 64'h7FFF_FFFF;
				end
				res.kind = KIND_MEAN;
				res.first = first_pos;
				res.stop = last_pos + 32'd1;
				res.val = quo[31:0];
				res.fresh = 1'b0;
				made = 1'b1;
			end
		end
		if (last) begin
			sum_acc = '0;
			count_acc = '0;
			run_live = 1'b0;
		end
		return made;
	endfunction

	function automatic value_t pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return $urandom_range(0, 64) - 32;
			default: return $urandom;
		endcase
	endfunction

	// send one word after a random gap, predict once it is taken
	task automatic push_sample(input pos_t istart, iend, pos, input value_t val,
		input logic miss, last);
		int gap;
		span_word_t res;
		gap = in_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_start <= istart;
		item_end <= iend;
		position <= pos;
		sample_value <= val;
		missing <= miss;
		item_last <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (track_sample(istart, iend, pos, val, miss, last, res))
			pending_spans.push_back(res);
		words_sent++;
	endtask

	// hold the sender until every result is out and the mean unit is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		if (!cfg_valid) cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LIMIT_ON: clip_on = data[0];
			REG_START:    clip_lo = data;
			REG_END:      clip_hi = data;
			REG_MODE:     run_mode = data[0];
			default: ;
		endcase
	endtask

	// idle the block, then load all four registers; junk above the flag bits
	task automatic apply_setup(input logic lim, input pos_t lo, hi, input logic md);
		logic [31:0] junk;
		settle();
		junk = $urandom;
		write_reg(REG_LIMIT_ON, {junk[31:1], lim});
		write_reg(REG_START, lo);
		write_reg(REG_END, hi);
		junk = $urandom;
		write_reg(REG_MODE, {junk[31:1], md});
		cfg_valid <= 1'b0;
	endtask

	// one item: a short walk over positions near its range
	task automatic stream_item(input pos_t win, input bit closed);
		pos_t lo, hi, p;
		int len, k;
		lo = win + $urandom_range(0, 60);
		hi = ($urandom_range(0, 9) == 0) ? lo - $urandom_range(0, 4) : lo + $urandom_range(1, 40);
		len = $urandom_range(1, 10);
		p = lo - $urandom_range(0, 2);
		for (k = 0; k < len; k++) begin
			push_sample(lo, hi, p, pick_value(), $urandom_range(0, 5) == 0,
				closed && k == len - 1);
			case ($urandom_range(0, 9))
				0: p = p + $urandom_range(2, 4);
				1: p = p - $urandom_range(1, 3);
				default: p = p + 32'd1;
			endcase
		end
	endtask

	// reset settings: extremes, missing and out-of-range samples, rounding ties
	task automatic test_average_basics();
		push_sample(100, 110, 100, 32'h7FFF_FFFF, 1'b0, 1'b0);
		push_sample(100, 110, 105, 32'h8000_0000, 1'b1, 1'b0);
		push_sample(100, 110, 109, 32'h8000_0000, 1'b0, 1'b0);
		push_sample(100, 110, 110, 32'h0000_0005, 1'b0, 1'b0);
		push_sample(100, 110, 99, 32'h0000_0005, 1'b0, 1'b0);
		push_sample(100, 110, 101, 32'h0000_0001, 1'b0, 1'b1);
		// item with every sample missing gives no mean
		push_sample(0, 32'hFFFF_FFFF, 7, 32'h0001_2340, 1'b1, 1'b0);
		push_sample(0, 32'hFFFF_FFFF, 8, 32'h0001_2340, 1'b1, 1'b1);
		// half-way means round away from zero
		push_sample(0, 4, 0, 32'sd1, 1'b0, 1'b0);
		push_sample(0, 4, 1, 32'sd2, 1'b0, 1'b1);
		push_sample(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, -32'sd1, 1'b0, 1'b0);
		push_sample(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, -32'sd2, 1'b0, 1'b1);
	endtask

	task automatic test_region_clip();
		apply_setup(1'b1, 200, 300, MODE_AVG);
		push_sample(150, 400, 199, 32'sd40, 1'b0, 1'b0);
		push_sample(150, 400, 200, 32'sd10, 1'b0, 1'b0);
		push_sample(150, 400, 299, 32'sd20, 1'b0, 1'b0);
		push_sample(150, 400, 300, 32'sd30, 1'b0, 1'b1);
	endtask

	// runs broken by gaps, missing values, dropped samples and item ends
	task automatic test_run_split();
		apply_setup(1'b0, 0, 32'hFFFF_FFFF, MODE_RUNS);
		push_sample(10, 20, 10, 32'h0001_0000, 1'b0, 1'b0);
		push_sample(10, 20, 11, 32'hFFFF_0000, 1'b0, 1'b0);
		push_sample(10, 20, 12, 32'h7FFF_FFFF, 1'b0, 1'b0);
		push_sample(10, 20, 14, 32'h8000_0000, 1'b0, 1'b0);
		push_sample(10, 20, 15, 32'h0000_0003, 1'b1, 1'b0);
		push_sample(10, 20, 16, 32'h0000_0004, 1'b0, 1'b0);
		push_sample(10, 20, 20, 32'h0000_0005, 1'b0, 1'b0);
		push_sample(10, 20, 17, 32'h0000_0006, 1'b0, 1'b1);
		push_sample(18, 30, 18, 32'h0000_0007, 1'b0, 1'b1);
	endtask

	task automatic test_random_streams();
		pos_t win, lo, hi;
		logic lim, md;
		int phase, goal;
		for (phase = 0; phase < PHASES; phase++) begin
			win = $urandom_range(0, 32'hFFFF_FE00);
			lim = 1'b1;
			md = 1'($urandom_range(0, 1));
			lo = win + $urandom_range(0, 30);
			hi = win + $urandom_range(10, 90);
			case (phase)
				0: begin
					lim = 1'b0;
					md = MODE_AVG;
				end
				1: begin
					lo = '0;
					hi = '1;
					md = MODE_RUNS;
				end
				2: begin
					lo = '0;
					hi = '0;
				end
				3: begin
					win = 32'hFFFF_FF00;
					lo = '1;
					hi = '1;
				end
				4: begin
					lo = win + 60;
					hi = win + 20;
				end
				5: begin
					win = '0;
					lo = '0;
					hi = $urandom_range(10, 90);
				end
				default: lim = 1'($urandom_range(0, 1));
			endcase
			apply_setup(lim, lo, hi, md);
			in_calm = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			goal = words_sent + PHASE_WORDS;
			while (words_sent < goal) begin
				if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
				if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
				case ($urandom_range(0, 7))
					0: push_sample($urandom, $urandom, $urandom, $urandom,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					1: stream_item(win, 1'b0);
					default: stream_item(win, 1'b1);
				endcase
			end
		end
		settle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_average_basics();
		test_region_clip();
		test_run_split();
		test_random_streams();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stall, then compare each taken word with the oldest prediction
	initial begin : result_check
		span_word_t got, want;
		int hold;
		wait (arst_n);
		forever begin
			hold = out_calm ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = {result_kind, span_start, span_end, result_value, new_run};
			if (pending_spans.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("t=%0t unexpected result: kind %0d span [%h,%h) value %h run %0d",
						$realtime, got.kind, got.first, got.stop, got.val, got.fresh);
			end else begin
				want = pending_spans.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"t=%0t bad result: exp kind %0d span [%h,%h) value %h run %0d,",
							" got kind %0d span [%h,%h) value %h run %0d"}, $realtime,
							want.kind, want.first, want.stop, want.val, want.fresh,
							got.kind, got.first, got.stop, got.val, got.fresh);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
